FILE: rtl/breakpoint_envelope_render_core_macros.svh
// ----------------------------------------------------------------------------
// breakpoint envelope render assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ENVELOPE_RENDER_CORE_MACROS_SVH
`define BREAKPOINT_ENVELOPE_RENDER_CORE_MACROS_SVH

// same-cycle implication
`define BPER_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bper_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bper_pkg
// shared types and constants of the breakpoint envelope renderer
// ----------------------------------------------------------------------------
package bper_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_RUN_DEF    = 64;

  // field widths
  localparam int TIME_W  = 32;
  localparam int LVL_W   = 16;
  localparam int DIV_W   = 32;
  localparam int PCNT_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT = 2'd1;

  // half an output lsb in the q20.16 accumulator
  localparam logic [35:0] ACC_ROUND = 36'd32768;

  typedef struct packed {
    logic              kind;
    logic [5:0]        point_index;
    logic [TIME_W-1:0] point_time;
    logic [LVL_W-1:0]  point_level;
    logic [TIME_W-1:0] start_frame;
    logic [6:0]        frame_count;
  } bper_in_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             last;
  } bper_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SCAN,
    ST_SEG,
    ST_LOADB,
    ST_DIV,
    ST_EVAL,
    ST_ACC,
    ST_OUT
  } state_e;

endpackage

FILE: rtl/bper_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bper_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bper_div import bper_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   trial_sub;
  logic             ge;

  // one trial subtraction per step
  assign trial     = {rem_q, quo_q[DIV_W-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign ge        = (trial >= {1'b0, dvs_q});

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/breakpoint_envelope_render_core.sv
`timescale 1ns / 1ps
// Steps: a cached ramp frame runs frame, multiply, add and output; a hold frame skips
// the multiply and add; an empty table goes from frame to output. A segment change
// adds a memory scan (point_count clamped to the table), one read per cycle; a new
// ramp adds a right point load and a divide. Loads write the table when accepted; a
// render run stalls input. Reset clears control state, interpolate to 1, point_count
// to 0; the table is undefined until loaded and has no clearing pass.
// ----------------------------------------------------------------------------
// breakpoint_envelope_render_core
// piecewise-linear automation envelope renderer with a breakpoint memory
// ----------------------------------------------------------------------------
module breakpoint_envelope_render_core import bper_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bper_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bper_out_t            out_data_o
);

  `include "breakpoint_envelope_render_core_macros.svh"

  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int RW  = $clog2(MAX_RUN + 1);
  localparam int IXW = (AW > 6) ? AW : 6;
  localparam int MW  = TIME_W + LVL_W;

  // configuration
  logic              interp_q;
  logic [PCNT_W-1:0] pcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= 1'b1;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INTERP: interp_q <= cfg_data_i[0];
        CFG_PCOUNT: pcount_q <= cfg_data_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // breakpoint memory, {time, level} per slot
  logic [MW-1:0] mem_q [MAX_POINTS];
  logic [MW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [IXW-1:0] widx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= {in_data_i.point_time, in_data_i.point_level};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  logic [TIME_W-1:0] rd_time;
  logic [LVL_W-1:0]  rd_lvl;
  assign rd_time = rdata_q[MW-1:LVL_W];
  assign rd_lvl  = rdata_q[LVL_W-1:0];

  // divider
  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DIV_W-1:0] div_dvs;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  bper_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // control and datapath registers
  state_e            state_q, state_d;
  logic [TIME_W-1:0] frame_q, frame_d;
  logic [RW-1:0]     left_q, left_d;
  logic [NW-1:0]     npts_q, npts_d;
  logic              need_scan_q, need_scan_d;
  logic [NW-1:0]     scan_i_q, scan_i_d;
  logic              scan_vld_q, scan_vld_d;
  logic [NW-1:0]     scan_tag_q, scan_tag_d;
  logic              found_q, found_d;
  logic [NW-1:0]     seg_q, seg_d;
  logic [TIME_W-1:0] seg_t_q, seg_t_d;
  logic [LVL_W-1:0]  seg_lvl_q, seg_lvl_d;
  logic [LVL_W-1:0]  lvl0_q, lvl0_d;
  logic              nxt_vld_q, nxt_vld_d;
  logic [TIME_W-1:0] nxt_t_q, nxt_t_d;
  logic              hold_q, hold_d;
  logic [LVL_W-1:0]  hold_val_q, hold_val_d;
  logic              neg_q, neg_d;
  logic [DIV_W-1:0]  prod_q, prod_d;
  logic [LVL_W-1:0]  res_q, res_d;
  logic              out_valid_q, out_valid_d;
  bper_out_t         out_q, out_d;

  // combinational helpers
  logic              accept;
  logic [NW-1:0]     npts_in;
  logic [RW-1:0]     count_in;
  logic              scan_rd;
  logic              seg_rd;
  logic [NW-1:0]     seg_p1;
  logic [LVL_W:0]    diff;
  logic [LVL_W-1:0]  diff_mag;
  logic [TIME_W-1:0] off;
  logic [2*DIV_W-1:0] prod_full;
  logic [35:0]       acc_y1;
  logic [35:0]       acc_term;
  logic [35:0]       acc;
  logic              out_load;
  logic [TIME_W-1:0] frame_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign npts_in  = (32'(pcount_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(pcount_q);
  assign count_in = (32'(in_data_i.frame_count) > MAX_RUN) ? RW'(MAX_RUN)
                                                           : RW'(in_data_i.frame_count);

  // load write port
  assign widx   = IXW'(in_data_i.point_index);
  assign mem_wa = widx[AW-1:0];
  assign mem_we = accept && (in_data_i.kind == KIND_LOAD) &&
                  (32'(in_data_i.point_index) < MAX_POINTS);

  // read port: scan reads or the right breakpoint of a ramp
  assign seg_p1  = seg_q + NW'(1);
  assign rd_en   = scan_rd || seg_rd;
  assign rd_addr = seg_rd ? seg_p1[AW-1:0] : scan_i_q[AW-1:0];

  // segment slope setup from the two breakpoints
  assign diff     = {1'b0, ~rd_lvl} - {1'b0, ~seg_lvl_q};
  assign diff_mag = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
  assign div_dvd  = {diff_mag, {(DIV_W-LVL_W){1'b0}}};
  assign div_dvs  = rd_time - seg_t_q;

  // offset times slope; the true product stays below 2^32
  assign off       = frame_q - seg_t_q;
  assign prod_full = off * div_quo;

  // q20.16 accumulator with rounding
  assign acc_y1   = {4'b0, ~seg_lvl_q, 16'b0};
  assign acc_term = neg_q ? (36'd0 - {4'b0, prod_q}) : {4'b0, prod_q};
  assign acc      = acc_y1 + acc_term + ACC_ROUND;

  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign frame_inc = frame_q + TIME_W'(1);

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    left_d      = left_q;
    npts_d      = npts_q;
    need_scan_d = need_scan_q;
    scan_i_d    = scan_i_q;
    scan_vld_d  = 1'b0;
    scan_tag_d  = scan_i_q;
    found_d     = found_q;
    seg_d       = seg_q;
    seg_t_d     = seg_t_q;
    seg_lvl_d   = seg_lvl_q;
    lvl0_d      = lvl0_q;
    nxt_vld_d   = nxt_vld_q;
    nxt_t_d     = nxt_t_q;
    hold_d      = hold_q;
    hold_val_d  = hold_val_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    scan_rd     = 1'b0;
    seg_rd      = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.kind == KIND_RENDER)) begin
          frame_d     = in_data_i.start_frame;
          left_d      = count_in;
          npts_d      = npts_in;
          need_scan_d = 1'b1;
          if (count_in != '0) begin
            state_d = ST_FRAME;
          end
        end
      end

      ST_FRAME: begin
        if (npts_q == '0) begin
          res_d   = '0;
          state_d = ST_OUT;
        end else if (need_scan_q) begin
          need_scan_d = 1'b0;
          scan_i_d    = '0;
          found_d     = 1'b0;
          nxt_vld_d   = 1'b0;
          state_d     = ST_SCAN;
        end else begin
          state_d = ST_EVAL;
        end
      end

      // one slot read per cycle, compare on the returned data
      ST_SCAN: begin
        if (scan_i_q < npts_q) begin
          scan_rd    = 1'b1;
          scan_vld_d = 1'b1;
          scan_i_d   = scan_i_q + NW'(1);
        end
        if (scan_vld_q) begin
          if (scan_tag_q == '0) begin
            lvl0_d = rd_lvl;
          end
          if (rd_time <= frame_q) begin
            found_d   = 1'b1;
            seg_d     = scan_tag_q;
            seg_t_d   = rd_time;
            seg_lvl_d = rd_lvl;
          end else if (!nxt_vld_q || (rd_time < nxt_t_q)) begin
            nxt_vld_d = 1'b1;
            nxt_t_d   = rd_time;
          end
          if (scan_tag_q == npts_q - NW'(1)) begin
            state_d = ST_SEG;
          end
        end
      end

      // pick hold level or start a ramp
      ST_SEG: begin
        if (!found_q) begin
          hold_d     = 1'b1;
          hold_val_d = ~lvl0_q;
          state_d    = ST_EVAL;
        end else if ((seg_q == npts_q - NW'(1)) || !interp_q) begin
          hold_d     = 1'b1;
          hold_val_d = ~seg_lvl_q;
          state_d    = ST_EVAL;
        end else begin
          hold_d  = 1'b0;
          seg_rd  = 1'b1;
          state_d = ST_LOADB;
        end
      end

      ST_LOADB: begin
        neg_d     = diff[LVL_W];
        div_start = 1'b1;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (hold_q) begin
          res_d   = hold_val_q;
          state_d = ST_OUT;
        end else begin
          prod_d  = prod_full[DIV_W-1:0];
          state_d = ST_ACC;
        end
      end

      // round, clamp to full scale
      ST_ACC: begin
        if (acc[35]) begin
          res_d = '0;
        end else if (acc[35:32] != 4'd0) begin
          res_d = '1;
        end else begin
          res_d = acc[31:16];
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d.level = res_q;
          out_d.last  = (left_q == RW'(1));
          frame_d     = frame_inc;
          left_d      = left_q - RW'(1);
          need_scan_d = (nxt_vld_q && (frame_inc == nxt_t_q)) || (frame_inc == '0);
          state_d     = (left_q == RW'(1)) ? ST_IDLE : ST_FRAME;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= '0;
      npts_q      <= '0;
      need_scan_q <= 1'b0;
      scan_i_q    <= '0;
      scan_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      nxt_vld_q   <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      npts_q      <= npts_d;
      need_scan_q <= need_scan_d;
      scan_i_q    <= scan_i_d;
      scan_vld_q  <= scan_vld_d;
      found_q     <= found_d;
      nxt_vld_q   <= nxt_vld_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    scan_tag_q <= scan_tag_d;
    seg_q      <= seg_d;
    seg_t_q    <= seg_t_d;
    seg_lvl_q  <= seg_lvl_d;
    lvl0_q     <= lvl0_d;
    nxt_t_q    <= nxt_t_d;
    hold_val_q <= hold_val_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `BPER_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == ST_DIV, "divider done outside divide")
  `BPER_ASSERT_IMPL(a_scan_tag_range, scan_vld_q, scan_tag_q < npts_q, "scan read past points")
  `BPER_ASSERT_IMPL(a_out_src, $rose(out_valid_q), $past(state_q) == ST_OUT, "stray output item")

endmodule
